/* hw/rtl/ptt_pkg.sv */
// Package for the periodic timer table: sizes, operation and result codes,
// controller state type and the controller/datapath command and status structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ptt_pkg;

   // Table geometry
   localparam int SLOT_COUNT  = 16;
   localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int MAX_RESULTS = 16;
   localparam int REP_W       = $clog2(MAX_RESULTS + 1);

   // Field widths
   localparam int KIND_W   = 2;
   localparam int ID_W     = 16;
   localparam int PERIOD_W = 31;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 3;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_KILL = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_EXPIRY     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_TICK_NONE  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_SET_OK     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_KILLED     = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_KILL_MISS  = 3'd5;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } ptt_state_type;

   // Controller to datapath
   typedef struct packed {
      logic                  load;    // capture a new transaction
      logic                  step;    // process slot idx this cycle
      logic                  finish;  // write final result
      logic [SLOT_IDX_W-1:0] idx;
   } ptt_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic match;      // set or kill hit at the current slot
      logic need_push;  // current step emits a result
      logic out_free;   // output register can take a result
   } ptt_sts_type;

endpackage

`default_nettype wire

/* hw/rtl/ptt_req_if.sv */
// Request channel interface of the periodic timer table.
// Depends on ptt_pkg for field widths.
`default_nettype none

interface ptt_req_if;
   import ptt_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ID_W-1:0]     timer_id;
   logic [PERIOD_W-1:0] period;

   modport source (output valid, output kind, output timer_id, output period, input ready);
   modport sink   (input valid, input kind, input timer_id, input period, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ptt_rsp_if.sv */
// Response channel interface of the periodic timer table.
// Depends on ptt_pkg for field widths.
`default_nettype none

interface ptt_rsp_if;
   import ptt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     expired_id;
   logic                last;

   modport source (output valid, output status, output expired_id, output last, input ready);
   modport sink   (input valid, input status, input expired_id, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/periodic_timer_table.sv */
// Top level of the periodic timer table: controller plus datapath on two channels.
// Depends on ptt_pkg, ptt_req_if, ptt_rsp_if, ptt_ctrl and ptt_datapath.
//
//   channel   | dir | payload                        | handshake
//   req_chan  | in  | kind, timer_id, period         | valid/ready
//   rsp_chan  | out | status, expired_id, last       | valid/ready
//
// A tick or an unmatched set/kill walks all SLOT_COUNT slots, one slot per cycle
// unless a held response stalls it; a set or kill that hits slot k stops there.
// A kind 3 transaction yields no response.
// The walk goes through the single slot read port; a held response stalls the walk
// only when another response must be written.
// Reset is synchronous and clears all slots at once; no clearing pass follows.
`default_nettype none

module periodic_timer_table (
   input  logic       clock,
   input  logic       reset,
   ptt_req_if.sink    req_chan,
   ptt_rsp_if.source  rsp_chan
);
   import ptt_pkg::*;

   ptt_cmd_type cmd;
   ptt_sts_type sts;

   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_chan.kind),
      .req_timer_id   (req_chan.timer_id),
      .req_period     (req_chan.period),
      .rsp_valid      (rsp_chan.valid),
      .rsp_status     (rsp_chan.status),
      .rsp_expired_id (rsp_chan.expired_id),
      .rsp_last       (rsp_chan.last),
      .rsp_ready      (rsp_chan.ready)
   );

   // Only an expiry can be followed by more responses of the same transaction
   a_last_on_non_expiry: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != STATUS_EXPIRY)) |-> rsp_chan.last)
      else $error("non-expiry response without last");

   // Identifier is zero unless the response reports an expiry
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != STATUS_EXPIRY)) |-> (rsp_chan.expired_id == '0))
      else $error("nonzero identifier on non-expiry response");

   // An unused kind produces no response
   a_none_silent: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.kind == KIND_NONE) && !rsp_chan.valid)
      |=> !rsp_chan.valid)
      else $error("response after unused kind");

   // No new transaction is taken while one is being walked
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.kind != KIND_NONE)) |=> !req_chan.ready)
      else $error("ready during slot walk");

endmodule

`default_nettype wire

/* hw/rtl/ptt_ctrl.sv */
// Controller of the periodic timer table: sequences the slot walk per transaction.
// Depends on ptt_pkg for the state type and the command and status structs.
`default_nettype none

module ptt_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [ptt_pkg::KIND_W-1:0]     req_kind,
   output logic                           req_ready,
   input  ptt_pkg::ptt_sts_type           sts,
   output ptt_pkg::ptt_cmd_type           cmd
);
   import ptt_pkg::*;

   ptt_state_type         state_ff, state_in;
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic                  last_slot;

   assign last_slot = (idx_ff == SLOT_IDX_W'(SLOT_COUNT - 1));

   // Drive commands from the current state
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.step   = (state_ff == ST_WALK) && !(sts.need_push && !sts.out_free);
      cmd.finish = (state_ff == ST_DONE) && sts.out_free;
      cmd.idx    = idx_ff;
   end

   // Next state and slot index
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_valid && (req_kind != KIND_NONE)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (cmd.step) begin
               idx_in = idx_ff + 1'b1;
               if (sts.match || last_slot) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ptt_datapath.sv */
// Datapath of the periodic timer table: slot registers, transaction registers,
// expiry hold stage and the response register. Depends on ptt_pkg.
`default_nettype none

module ptt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  ptt_pkg::ptt_cmd_type            cmd,
   output ptt_pkg::ptt_sts_type            sts,
   input  logic [ptt_pkg::KIND_W-1:0]      req_kind,
   input  logic [ptt_pkg::ID_W-1:0]        req_timer_id,
   input  logic [ptt_pkg::PERIOD_W-1:0]    req_period,
   output logic                            rsp_valid,
   output logic [ptt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ptt_pkg::ID_W-1:0]        rsp_expired_id,
   output logic                            rsp_last,
   input  logic                            rsp_ready
);
   import ptt_pkg::*;

   // Slot table
   logic [ID_W-1:0]     slot_id_ff     [SLOT_COUNT];
   logic [PERIOD_W-1:0] slot_period_ff [SLOT_COUNT];
   logic [COUNT_W-1:0]  slot_count_ff  [SLOT_COUNT];

   // Transaction registers
   logic [KIND_W-1:0]     kind_ff;
   logic [ID_W-1:0]       tid_ff;
   logic [PERIOD_W-1:0]   tper_ff;
   logic                  pend_valid_ff;
   logic [ID_W-1:0]       pend_id_ff;
   logic [REP_W-1:0]      rep_cnt_ff;
   logic                  hit_ff;
   logic                  free_valid_ff;
   logic [SLOT_IDX_W-1:0] free_idx_ff;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_load;

   // Current slot view
   logic [ID_W-1:0]     cur_id;
   logic [PERIOD_W-1:0] cur_per;
   logic [COUNT_W-1:0]  cur_cnt;
   logic [COUNT_W-1:0]  dec_cnt;
   logic                active, expire;
   logic                is_tick, is_set, is_kill;
   logic                slot_match, capture, out_free, free_write;

   // Slot write port
   logic                  wr_en;
   logic [SLOT_IDX_W-1:0] wr_idx;
   logic [ID_W-1:0]       wr_id;
   logic [PERIOD_W-1:0]   wr_per;
   logic [COUNT_W-1:0]    wr_cnt;

   assign cur_id  = slot_id_ff[cmd.idx];
   assign cur_per = slot_period_ff[cmd.idx];
   assign cur_cnt = slot_count_ff[cmd.idx];
   assign dec_cnt = cur_cnt - COUNT_W'(1);
   assign active  = (cur_per != '0);
   assign expire  = dec_cnt[COUNT_W-1];

   assign is_tick = (kind_ff == KIND_TICK);
   assign is_set  = (kind_ff == KIND_SET);
   assign is_kill = (kind_ff == KIND_KILL);

   // Set matches live slots only, kill matches any slot
   assign slot_match = (is_set && active && (cur_id == tid_ff))
                    || (is_kill && (cur_id == tid_ff));
   assign capture    = is_tick && active && expire && (rep_cnt_ff < REP_W'(MAX_RESULTS));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign free_write = cmd.finish && is_set && !hit_ff && free_valid_ff;

   assign sts.match     = slot_match;
   assign sts.need_push = capture && pend_valid_ff;
   assign sts.out_free  = out_free;

   // Select what goes into the slot table
   always_comb begin
      wr_en  = 1'b0;
      wr_idx = cmd.idx;
      wr_id  = cur_id;
      wr_per = cur_per;
      wr_cnt = cur_cnt;
      if (cmd.step) begin
         case (kind_ff)
            KIND_TICK: begin
               if (active) begin
                  wr_en  = 1'b1;
                  wr_cnt = expire ? {1'b0, cur_per} : dec_cnt;
               end
            end
            KIND_SET: begin
               if (slot_match) begin
                  wr_en  = 1'b1;
                  wr_per = tper_ff;
                  wr_cnt = '0;
               end
            end
            KIND_KILL: begin
               if (slot_match) begin
                  wr_en  = 1'b1;
                  wr_id  = '0;
                  wr_per = '0;
                  wr_cnt = '0;
               end
            end
            default: wr_en = 1'b0;
         endcase
      end else if (free_write) begin
         wr_en  = 1'b1;
         wr_idx = free_idx_ff;
         wr_id  = tid_ff;
         wr_per = tper_ff;
         wr_cnt = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_id_ff[i]     <= '0;
            slot_period_ff[i] <= '0;
            slot_count_ff[i]  <= '0;
         end
      end else if (wr_en) begin
         slot_id_ff[wr_idx]     <= wr_id;
         slot_period_ff[wr_idx] <= wr_per;
         slot_count_ff[wr_idx]  <= wr_cnt;
      end
   end

   // Capture the transaction and track the walk
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rep_cnt_ff    <= '0;
         hit_ff        <= 1'b0;
         free_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         pend_valid_ff <= 1'b0;
         rep_cnt_ff    <= '0;
         hit_ff        <= 1'b0;
         free_valid_ff <= 1'b0;
      end else if (cmd.step) begin
         if (capture) begin
            pend_valid_ff <= 1'b1;
            rep_cnt_ff    <= rep_cnt_ff + 1'b1;
         end
         if (slot_match) begin
            hit_ff <= 1'b1;
         end
         if (is_set && !active && !free_valid_ff) begin
            free_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         tid_ff  <= req_timer_id;
         tper_ff <= req_period;
      end
      if (cmd.step && capture) begin
         pend_id_ff <= cur_id;
      end
      if (cmd.step && is_set && !active && !free_valid_ff) begin
         free_idx_ff <= cmd.idx;
      end
   end

   // Build the next response
   always_comb begin
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.step && sts.need_push) begin
         rsp_load      = 1'b1;
         rsp_status_in = STATUS_EXPIRY;
         rsp_id_in     = pend_id_ff;
         rsp_last_in   = 1'b0;
      end else if (cmd.finish) begin
         rsp_load    = 1'b1;
         rsp_id_in   = '0;
         rsp_last_in = 1'b1;
         case (kind_ff)
            KIND_TICK: begin
               if (pend_valid_ff) begin
                  rsp_status_in = STATUS_EXPIRY;
                  rsp_id_in     = pend_id_ff;
               end else begin
                  rsp_status_in = STATUS_TICK_NONE;
               end
            end
            KIND_SET:  rsp_status_in = (hit_ff || free_valid_ff) ? STATUS_SET_OK
                                                                  : STATUS_TABLE_FULL;
            KIND_KILL: rsp_status_in = hit_ff ? STATUS_KILLED : STATUS_KILL_MISS;
            default:   rsp_status_in = STATUS_TICK_NONE;
         endcase
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire
